>>> rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants for the i2c master byte engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned LimitWidth     = 8;
    localparam int unsigned ByteWidth      = 8;
    localparam int unsigned BitCountWidth  = 4;
    localparam logic [LimitWidth-1:0] AckPollLimitReset = 8'd250;
    localparam logic [BitCountWidth-1:0] BitsPerByte    = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST_SDA   = 5'd1,
        PH_ST_SCL   = 5'd2,
        PH_SP_RISE  = 5'd3,
        PH_WR_DATA  = 5'd4,
        PH_WR_HIGH  = 5'd5,
        PH_WR_LOW   = 5'd6,
        PH_AK_REL   = 5'd7,
        PH_AK_HIGH  = 5'd8,
        PH_AK_POLL  = 5'd9,
        PH_RD_LOW   = 5'd10,
        PH_RD_HIGH  = 5'd11,
        PH_KA_DRIVE = 5'd12,
        PH_KA_HIGH  = 5'd13,
        PH_KA_LOW   = 5'd14
    } phase_t;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef struct packed {
        logic                 cmd_valid;
        op_t                  kind;
        logic [ByteWidth-1:0] tx_byte;
        logic                 send_ack;
        logic                 sda_sample;
    } tick_t;

    typedef struct packed {
        logic                 scl_level;
        logic                 sda_level;
        logic                 sda_released;
        logic                 busy_res;
        logic                 done_res;
        logic [ByteWidth-1:0] rx_byte;
        logic                 no_ack;
    } result_t;

endpackage

>>> rtl/core/i2cm_tick_if.sv
// ----------------------------------------------------------------------------
// i2cm_tick_if
// tick channel: one bus-delay tick with optional command and sampled sda
// ----------------------------------------------------------------------------
interface i2cm_tick_if;

    logic                            valid;
    logic                            ready;
    logic                            cmd_valid;
    logic [1:0]                      kind;
    logic [i2cm_pkg::ByteWidth-1:0]  tx_byte;
    logic                            send_ack;
    logic                            sda_sample;

    modport source (
        output valid, cmd_valid, kind, tx_byte, send_ack, sda_sample,
        input  ready
    );

    modport sink (
        input  valid, cmd_valid, kind, tx_byte, send_ack, sda_sample,
        output ready
    );

endinterface

>>> rtl/core/i2cm_result_if.sv
// ----------------------------------------------------------------------------
// i2cm_result_if
// result channel: line levels and status for one tick
// ----------------------------------------------------------------------------
interface i2cm_result_if;

    logic                            valid;
    logic                            ready;
    logic                            scl_level;
    logic                            sda_level;
    logic                            sda_released;
    logic                            busy_res;
    logic                            done_res;
    logic [i2cm_pkg::ByteWidth-1:0]  rx_byte;
    logic                            no_ack;

    modport source (
        output valid, scl_level, sda_level, sda_released, busy_res, done_res,
               rx_byte, no_ack,
        input  ready
    );

    modport sink (
        input  valid, scl_level, sda_level, sda_released, busy_res, done_res,
               rx_byte, no_ack,
        output ready
    );

endinterface

>>> rtl/core/i2cm_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cm_cfg_if
// configuration write channel for the acknowledge poll limit
// ----------------------------------------------------------------------------
interface i2cm_cfg_if;

    logic                             valid;
    logic                             ready;
    logic [i2cm_pkg::LimitWidth-1:0]  data;

    modport source (
        output valid, data,
        input  ready
    );

    modport sink (
        input  valid, data,
        output ready
    );

endinterface

>>> rtl/core/i2cm_sequencer.sv
// ----------------------------------------------------------------------------
// i2cm_sequencer
// phase sequencer: one line action per tick, bit counters and shifters
// ----------------------------------------------------------------------------
module i2cm_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  i2cm_pkg::tick_t                     tick,
    input  logic [i2cm_pkg::LimitWidth-1:0]     ack_poll_limit,
    output i2cm_pkg::result_t                   result
);

    i2cm_pkg::phase_t                          phase_reg, phase_next;
    i2cm_pkg::op_t                             op_reg, op_next;
    logic [i2cm_pkg::BitCountWidth-1:0]        bit_count_reg, bit_count_next;
    logic [i2cm_pkg::ByteWidth-1:0]            shift_out_reg, shift_out_next;
    logic [i2cm_pkg::ByteWidth-1:0]            shift_in_reg, shift_in_next;
    logic [i2cm_pkg::LimitWidth-1:0]           poll_count_reg, poll_count_next;
    logic                                      ack_choice_reg, ack_choice_next;
    logic                                      scl_reg, scl_next;
    logic                                      sda_reg, sda_next;
    logic                                      rel_reg, rel_next;
    logic                                      done;
    logic                                      nack;

    // next state and datapath
    always_comb
    begin
        phase_next      = phase_reg;
        op_next         = op_reg;
        bit_count_next  = bit_count_reg;
        shift_out_next  = shift_out_reg;
        shift_in_next   = shift_in_reg;
        poll_count_next = poll_count_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        rel_next        = rel_reg;
        unique case (phase_reg)
            i2cm_pkg::PH_ST_SDA:
            begin
                sda_next   = 1'b0;
                phase_next = i2cm_pkg::PH_ST_SCL;
            end
            i2cm_pkg::PH_ST_SCL:
            begin
                scl_next   = 1'b0;
                phase_next = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::PH_SP_RISE:
            begin
                scl_next   = 1'b1;
                sda_next   = 1'b1;
                rel_next   = 1'b0;
                phase_next = i2cm_pkg::PH_IDLE;
            end
            i2cm_pkg::PH_WR_DATA:
            begin
                scl_next       = 1'b0;
                sda_next       = shift_out_reg[i2cm_pkg::ByteWidth-1];
                rel_next       = 1'b0;
                shift_out_next = {shift_out_reg[i2cm_pkg::ByteWidth-2:0], 1'b0};
                bit_count_next = bit_count_reg + 1'b1;
                phase_next     = i2cm_pkg::PH_WR_HIGH;
            end
            i2cm_pkg::PH_WR_HIGH:
            begin
                scl_next   = 1'b1;
                phase_next = i2cm_pkg::PH_WR_LOW;
            end
            i2cm_pkg::PH_WR_LOW:
            begin
                scl_next   = 1'b0;
                phase_next = (bit_count_reg >= i2cm_pkg::BitsPerByte) ?
                             i2cm_pkg::PH_AK_REL : i2cm_pkg::PH_WR_DATA;
            end
            i2cm_pkg::PH_AK_REL:
            begin
                scl_next        = 1'b0;
                sda_next        = 1'b1;
                rel_next        = 1'b1;
                poll_count_next = '0;
                phase_next      = i2cm_pkg::PH_AK_HIGH;
            end
            i2cm_pkg::PH_AK_HIGH:
            begin
                scl_next   = 1'b1;
                phase_next = i2cm_pkg::PH_AK_POLL;
            end
            i2cm_pkg::PH_AK_POLL:
            begin
                if (!tick.sda_sample)
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_IDLE;
                end
                else if (poll_count_reg >= ack_poll_limit)
                begin
                    // timeout: open a stop condition
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    rel_next   = 1'b0;
                    phase_next = i2cm_pkg::PH_SP_RISE;
                end
                else
                begin
                    poll_count_next = poll_count_reg + 1'b1;
                end
            end
            i2cm_pkg::PH_RD_LOW:
            begin
                scl_next   = 1'b0;
                sda_next   = 1'b1;
                rel_next   = 1'b1;
                phase_next = i2cm_pkg::PH_RD_HIGH;
            end
            i2cm_pkg::PH_RD_HIGH:
            begin
                scl_next       = 1'b1;
                shift_in_next  = {shift_in_reg[i2cm_pkg::ByteWidth-2:0], tick.sda_sample};
                bit_count_next = bit_count_reg + 1'b1;
                phase_next     = (bit_count_next >= i2cm_pkg::BitsPerByte) ?
                                 i2cm_pkg::PH_KA_DRIVE : i2cm_pkg::PH_RD_LOW;
            end
            i2cm_pkg::PH_KA_DRIVE:
            begin
                scl_next   = 1'b0;
                sda_next   = !ack_choice_reg;
                rel_next   = 1'b0;
                phase_next = i2cm_pkg::PH_KA_HIGH;
            end
            i2cm_pkg::PH_KA_HIGH:
            begin
                scl_next   = 1'b1;
                phase_next = i2cm_pkg::PH_KA_LOW;
            end
            i2cm_pkg::PH_KA_LOW:
            begin
                scl_next   = 1'b0;
                phase_next = i2cm_pkg::PH_IDLE;
            end
            default:
            begin
                // idle and unused codes: take a command
                phase_next = i2cm_pkg::PH_IDLE;
                if (tick.cmd_valid)
                begin
                    op_next = tick.kind;
                    unique case (tick.kind)
                        i2cm_pkg::OP_START:
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            rel_next   = 1'b0;
                            phase_next = i2cm_pkg::PH_ST_SDA;
                        end
                        i2cm_pkg::OP_STOP:
                        begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b0;
                            rel_next   = 1'b0;
                            phase_next = i2cm_pkg::PH_SP_RISE;
                        end
                        i2cm_pkg::OP_WRITE:
                        begin
                            scl_next       = 1'b0;
                            sda_next       = tick.tx_byte[i2cm_pkg::ByteWidth-1];
                            rel_next       = 1'b0;
                            shift_out_next = {tick.tx_byte[i2cm_pkg::ByteWidth-2:0], 1'b0};
                            bit_count_next = {{(i2cm_pkg::BitCountWidth-1){1'b0}}, 1'b1};
                            phase_next     = i2cm_pkg::PH_WR_HIGH;
                        end
                        default:
                        begin
                            shift_in_next   = '0;
                            bit_count_next  = '0;
                            ack_choice_next = tick.send_ack;
                            scl_next        = 1'b0;
                            sda_next        = 1'b1;
                            rel_next        = 1'b1;
                            phase_next      = i2cm_pkg::PH_RD_HIGH;
                        end
                    endcase
                end
            end
        endcase
    end

    // status outputs
    always_comb
    begin
        done = 1'b0;
        nack = 1'b0;
        unique case (phase_reg)
            i2cm_pkg::PH_ST_SCL,
            i2cm_pkg::PH_KA_LOW:
            begin
                done = 1'b1;
            end
            i2cm_pkg::PH_SP_RISE:
            begin
                done = 1'b1;
                nack = (op_reg == i2cm_pkg::OP_WRITE);
            end
            i2cm_pkg::PH_AK_POLL:
            begin
                done = !tick.sda_sample;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.scl_level    = scl_next;
        result.sda_level    = sda_next;
        result.sda_released = rel_next;
        result.busy_res     = (phase_next != i2cm_pkg::PH_IDLE);
        result.done_res     = done;
        result.rx_byte      = shift_in_next;
        result.no_ack       = nack;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= i2cm_pkg::PH_IDLE;
            op_reg         <= i2cm_pkg::OP_START;
            bit_count_reg  <= '0;
            shift_out_reg  <= '0;
            shift_in_reg   <= '0;
            poll_count_reg <= '0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            rel_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            op_reg         <= op_next;
            bit_count_reg  <= bit_count_next;
            shift_out_reg  <= shift_out_next;
            shift_in_reg   <= shift_in_next;
            poll_count_reg <= poll_count_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            rel_reg        <= rel_next;
        end
    end

endmodule

>>> rtl/core/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// i2c master byte engine advanced by bus-delay ticks
//
// tick_ch carries one bus-delay tick per transfer: an optional command
// (start, stop, write byte, read byte) and the sampled sda level. commands
// offered while a command is in progress are ignored.
// res_ch returns one result per tick: driven scl/sda levels, sda release,
// busy, done, the receive shift register and the acknowledge timeout flag.
// cfg_ch writes the acknowledge poll limit (reset value 250); write it only
// while the engine is idle.
// each tick's result is registered, valid in the cycle after the transfer.
// throughput: one tick per cycle unless res_ch stalls; the sequencer advances
// one phase per tick, through one registered step into the result register.
// reset: lines scl high, sda high and driven, engine idle, limit 250.
// a stalled res_ch holds its result; a new tick is taken in the same cycle
// that the waiting result is transferred.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
    input  logic            clk,
    input  logic            rst_n,
    i2cm_tick_if.sink       tick_ch,
    i2cm_result_if.source   res_ch,
    i2cm_cfg_if.sink        cfg_ch
);

    logic [i2cm_pkg::LimitWidth-1:0]  limit_reg;
    logic                             out_valid_reg;
    i2cm_pkg::result_t                res_reg;
    i2cm_pkg::result_t                res_next;
    i2cm_pkg::tick_t                  tick;
    logic                             step;

    assign tick_ch.ready = !out_valid_reg || res_ch.ready;
    assign step          = tick_ch.valid && tick_ch.ready;
    assign cfg_ch.ready  = 1'b1;

    always_comb
    begin
        tick.cmd_valid  = tick_ch.cmd_valid;
        tick.kind       = i2cm_pkg::op_t'(tick_ch.kind);
        tick.tx_byte    = tick_ch.tx_byte;
        tick.send_ack   = tick_ch.send_ack;
        tick.sda_sample = tick_ch.sda_sample;
    end

    i2cm_sequencer u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .tick           (tick),
        .ack_poll_limit (limit_reg),
        .result         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= i2cm_pkg::AckPollLimitReset;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            limit_reg <= cfg_ch.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.scl_level    = res_reg.scl_level;
    assign res_ch.sda_level    = res_reg.sda_level;
    assign res_ch.sda_released = res_reg.sda_released;
    assign res_ch.busy_res     = res_reg.busy_res;
    assign res_ch.done_res     = res_reg.done_res;
    assign res_ch.rx_byte      = res_reg.rx_byte;
    assign res_ch.no_ack       = res_reg.no_ack;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the i2c master byte engine
//
// every tick transfer is run through a local model of the phase sequencer.
// the resulting line levels and status are queued and compared field by
// field with each result transfer. a short table of ticks with hand-written
// results opens the run. directed commands follow, then random command
// sequences with random content, noise and ignored commands while busy.
// the poll limit is rewritten between phases, with varied sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        tick_t   t;
        result_t r;
    } tick_row_t;

    typedef struct {
        op_t            kind;
        logic [7:0]     tx;
        logic           ack;
        int             highs;
        logic [7:0]     pattern;
    } cmd_row_t;

    logic clk = 1'b0;
    logic rst_n;

    i2cm_tick_if   tick_ch ();
    i2cm_result_if res_ch ();
    i2cm_cfg_if    cfg_ch ();

    i2c_master_byte_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick_ch (tick_ch),
        .res_ch  (res_ch),
        .cfg_ch  (cfg_ch)
    );

    // model state
    phase_t                 eng_phase = PH_IDLE;
    op_t                    eng_op    = OP_START;
    logic [BitCountWidth-1:0] eng_bits = '0;
    logic [ByteWidth-1:0]   eng_sout  = '0;
    logic [ByteWidth-1:0]   eng_sin   = '0;
    logic [LimitWidth-1:0]  eng_polls = '0;
    logic                   eng_ack   = 1'b0;
    logic                   scl_q     = 1'b1;
    logic                   sda_q     = 1'b1;
    logic                   rel_q     = 1'b0;
    logic [LimitWidth-1:0]  ack_limit = AckPollLimitReset;

    result_t    expected_status[$];
    logic       fix_on;
    result_t    fix_res;
    int         errors       = 0;
    int         results_seen = 0;
    int         engine_ticks = 0;
    int         cmd_no       = 0;
    int         gap_pct      = 0;
    int         stall_pct    = 0;
    bit         pause_on     = 1'b0;

    tick_row_t  dir_ticks[12];
    cmd_row_t   dir_cmds[6];

    always #1 clk = ~clk;

    function automatic void set_lines(logic scl, logic sda, logic rel);
        scl_q = scl;
        sda_q = sda;
        rel_q = rel;
    endfunction

    function automatic void shift_bit_out();
        set_lines(1'b0, eng_sout[7], 1'b0);
        eng_sout  = {eng_sout[6:0], 1'b0};
        eng_bits  = eng_bits + 1'b1;
        eng_phase = PH_WR_HIGH;
    endfunction

    function automatic result_t advance_engine(tick_t t);
        result_t r;
        logic    done;
        logic    nack;
        done = 1'b0;
        nack = 1'b0;
        case (eng_phase)
            PH_ST_SDA:
            begin
                sda_q     = 1'b0;
                eng_phase = PH_ST_SCL;
            end
            PH_ST_SCL:
            begin
                scl_q     = 1'b0;
                eng_phase = PH_IDLE;
                done      = 1'b1;
            end
            PH_SP_RISE:
            begin
                set_lines(1'b1, 1'b1, 1'b0);
                eng_phase = PH_IDLE;
                done      = 1'b1;
                nack      = (eng_op == OP_WRITE);
            end
            PH_WR_DATA:
                shift_bit_out();
            PH_WR_HIGH:
            begin
                scl_q     = 1'b1;
                eng_phase = PH_WR_LOW;
            end
            PH_WR_LOW:
            begin
                scl_q = 1'b0;
                if (eng_bits >= BitsPerByte)
                    eng_phase = PH_AK_REL;
                else
                    eng_phase = PH_WR_DATA;
            end
            PH_AK_REL:
            begin
                set_lines(1'b0, 1'b1, 1'b1);
                eng_polls = '0;
                eng_phase = PH_AK_HIGH;
            end
            PH_AK_HIGH:
            begin
                scl_q     = 1'b1;
                eng_phase = PH_AK_POLL;
            end
            PH_AK_POLL:
            begin
                if (!t.sda_sample)
                begin
                    scl_q     = 1'b0;
                    eng_phase = PH_IDLE;
                    done      = 1'b1;
                end
                else if (eng_polls >= ack_limit)
                begin
                    // acknowledge timeout: engine runs its own stop
                    set_lines(1'b0, 1'b0, 1'b0);
                    eng_phase = PH_SP_RISE;
                end
                else
                    eng_polls = eng_polls + 1'b1;
            end
            PH_RD_LOW:
            begin
                set_lines(1'b0, 1'b1, 1'b1);
                eng_phase = PH_RD_HIGH;
            end
            PH_RD_HIGH:
            begin
                scl_q    = 1'b1;
                eng_sin  = {eng_sin[6:0], t.sda_sample};
                eng_bits = eng_bits + 1'b1;
                if (eng_bits >= BitsPerByte)
                    eng_phase = PH_KA_DRIVE;
                else
                    eng_phase = PH_RD_LOW;
            end
            PH_KA_DRIVE:
            begin
                set_lines(1'b0, !eng_ack, 1'b0);
                eng_phase = PH_KA_HIGH;
            end
            PH_KA_HIGH:
            begin
                scl_q     = 1'b1;
                eng_phase = PH_KA_LOW;
            end
            PH_KA_LOW:
            begin
                scl_q     = 1'b0;
                eng_phase = PH_IDLE;
                done      = 1'b1;
            end
            default:
            begin
                eng_phase = PH_IDLE;
                if (t.cmd_valid)
                begin
                    eng_op = t.kind;
                    case (t.kind)
                        OP_START:
                        begin
                            set_lines(1'b1, 1'b1, 1'b0);
                            eng_phase = PH_ST_SDA;
                        end
                        OP_STOP:
                        begin
                            set_lines(1'b0, 1'b0, 1'b0);
                            eng_phase = PH_SP_RISE;
                        end
                        OP_WRITE:
                        begin
                            eng_sout = t.tx_byte;
                            eng_bits = '0;
                            shift_bit_out();
                        end
                        default:
                        begin
                            eng_sin   = '0;
                            eng_bits  = '0;
                            eng_ack   = t.send_ack;
                            set_lines(1'b0, 1'b1, 1'b1);
                            eng_phase = PH_RD_HIGH;
                        end
                    endcase
                end
            end
        endcase
        r.scl_level    = scl_q;
        r.sda_level    = sda_q;
        r.sda_released = rel_q;
        r.busy_res     = (eng_phase != PH_IDLE);
        r.done_res     = done;
        r.rx_byte      = eng_sin;
        r.no_ack       = nack;
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        errors++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                got = '{res_ch.scl_level, res_ch.sda_level, res_ch.sda_released,
                        res_ch.busy_res, res_ch.done_res, res_ch.rx_byte,
                        res_ch.no_ack};
                if (expected_status.size() == 0)
                    report("result transfer with nothing expected");
                else
                begin
                    want = expected_status.pop_front();
                    compare_field("scl_level", got.scl_level, want.scl_level);
                    compare_field("sda_level", got.sda_level, want.sda_level);
                    compare_field("sda_released", got.sda_released, want.sda_released);
                    compare_field("busy_res", got.busy_res, want.busy_res);
                    compare_field("done_res", got.done_res, want.done_res);
                    compare_field("rx_byte", got.rx_byte, want.rx_byte);
                    compare_field("no_ack", got.no_ack, want.no_ack);
                end
            end
            if (tick_ch.valid && tick_ch.ready)
            begin
                want = advance_engine('{tick_ch.cmd_valid, op_t'(tick_ch.kind),
                                        tick_ch.tx_byte, tick_ch.send_ack,
                                        tick_ch.sda_sample});
                if (fix_on)
                    want = fix_res;
                expected_status.push_back(want);
            end
        end
    end

    always @(posedge clk)
        res_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_tick(input tick_t t, input bit has_fix = 1'b0,
                             input result_t fix = '0);
        while ($urandom_range(99) < gap_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.cmd_valid  <= t.cmd_valid;
        tick_ch.kind       <= t.kind;
        tick_ch.tx_byte    <= t.tx_byte;
        tick_ch.send_ack   <= t.send_ack;
        tick_ch.sda_sample <= t.sda_sample;
        fix_on             <= has_fix;
        fix_res            <= fix;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
    endtask

    function automatic tick_t busy_tick();
        tick_t t;
        t = '{1'($urandom_range(1)), op_t'($urandom_range(3)),
              8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1))};
        return t;
    endfunction

    // called in the step of the last tick transfer
    task automatic wait_results_in();
        tick_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_status.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        tick_t t;
        wait_results_in();
        while (eng_phase != PH_IDLE)
        begin
            t = busy_tick();
            t.cmd_valid  = 1'b0;
            t.sda_sample = 1'b0;
            send_tick(t);
            wait_results_in();
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        ack_limit = value;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_command(input op_t kind, input logic [7:0] tx, input logic ack,
                               input int highs, input logic [7:0] pattern);
        tick_t t;
        int    fill;
        int    polls;
        t = busy_tick();
        t.cmd_valid = 1'b1;
        t.kind      = kind;
        t.tx_byte   = tx;
        t.send_ack  = ack;
        send_tick(t);
        case (kind)
            OP_START: fill = 2;
            OP_STOP:  fill = 1;
            OP_WRITE: fill = 25;
            default:  fill = 18;
        endcase
        for (int i = 1; i <= fill; i++)
        begin
            t = busy_tick();
            if (kind == OP_READ && i[0])
                t.sda_sample = pattern[7 - (i - 1) / 2];
            send_tick(t);
        end
        polls = 0;
        if (kind == OP_WRITE)
        begin
            polls = (highs <= int'(ack_limit)) ? highs : int'(ack_limit) + 1;
            for (int p = 0; p < polls; p++)
            begin
                t = busy_tick();
                t.sda_sample = 1'b1;
                send_tick(t);
            end
            // acknowledge, or the stop rise after a timeout
            t = busy_tick();
            if (highs <= int'(ack_limit))
                t.sda_sample = 1'b0;
            send_tick(t);
            polls++;
        end
        engine_ticks += 1 + fill + polls;
    endtask

    task automatic run_random(input int n);
        int    base;
        int    p;
        int    highs;
        tick_t t;
        base = engine_ticks;
        while (engine_ticks - base < n)
        begin
            cmd_no++;
            if (pause_on && cmd_no % 25 == 0)
                wait_results_in();
            p = $urandom_range(99);
            if (p < 8)
            begin
                t = busy_tick();
                t.cmd_valid = 1'b0;
                send_tick(t);
            end
            else
            begin
                if (ack_limit <= 8)
                    highs = $urandom_range(int'(ack_limit) + 1);
                else if (p < 11)
                    highs = int'(ack_limit) + 1;
                else if (p < 14)
                    highs = ack_limit;
                else
                    highs = $urandom_range(3);
                run_command(op_t'($urandom_range(3)), 8'($urandom_range(255)),
                            1'($urandom_range(1)), highs, 8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        tick_ch.valid      = 1'b0;
        tick_ch.cmd_valid  = 1'b0;
        tick_ch.kind       = OP_START;
        tick_ch.tx_byte    = '0;
        tick_ch.send_ack   = 1'b0;
        tick_ch.sda_sample = 1'b1;
        res_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        fix_on             = 1'b0;
        fix_res            = '0;

        // idle ticks, start and stop, commands offered while busy
        dir_ticks = '{
            '{'{1'b0, OP_WRITE, 8'hFF, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{'{1'b1, OP_START, 8'h00, 1'b0, 1'b0}, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{'{1'b1, OP_STOP,  8'hFF, 1'b1, 1'b1}, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{'{1'b0, OP_READ,  8'h00, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
            '{'{1'b1, OP_STOP,  8'h00, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{'{1'b1, OP_WRITE, 8'hFF, 1'b1, 1'b0}, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
            '{'{1'b1, OP_STOP,  8'h55, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{'{1'b0, OP_START, 8'hAA, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
            '{'{1'b0, OP_READ,  8'hFF, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{'{1'b1, OP_START, 8'hFF, 1'b1, 1'b1}, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{'{1'b1, OP_START, 8'h00, 1'b0, 1'b0}, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
            '{'{1'b1, OP_READ,  8'hFF, 1'b1, 1'b0}, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}}
        };
        // byte extremes, ack on the last allowed poll, ack timeout, ack and nack
        dir_cmds = '{
            '{OP_WRITE, 8'h00, 1'b0, 0,   8'h00},
            '{OP_WRITE, 8'hFF, 1'b1, 2,   8'h00},
            '{OP_WRITE, 8'hA5, 1'b0, 250, 8'h00},
            '{OP_WRITE, 8'h5A, 1'b1, 251, 8'h00},
            '{OP_READ,  8'h00, 1'b1, 0,   8'hFF},
            '{OP_READ,  8'hFF, 1'b0, 0,   8'h00}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_ticks[i])
            send_tick(dir_ticks[i].t, 1'b1, dir_ticks[i].r);
        foreach (dir_cmds[i])
            run_command(dir_cmds[i].kind, dir_cmds[i].tx, dir_cmds[i].ack,
                        dir_cmds[i].highs, dir_cmds[i].pattern);
        run_random(70);

        write_limit(8'd0);
        gap_pct = 71;
        run_random(70);

        write_limit(8'd255);
        gap_pct   = 0;
        stall_pct = 71;
        run_random(70);

        write_limit(8'($urandom_range(2, 9)));
        gap_pct   = 16;
        stall_pct = 16;
        run_random(70);

        write_limit(8'd1);
        gap_pct   = 0;
        stall_pct = 0;
        pause_on  = 1'b1;
        run_random(70);

        wait_results_in();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
